// File: hw/rtl/rmtg_pkg.sv
// Package for the melody tone generator: beat types, note field positions and the tone table.
// Used by rmtg_store and rom_melody_tone_generator; depends on nothing else.
`timescale 1ns / 1ps

package rmtg_pkg;

    localparam int STORE_DEPTH_DEFAULT = 256;
    localparam int ADDR_W              = 8;
    localparam int NOTE_W              = 6;
    localparam int DIV_W               = 15;
    localparam int DUTY_W              = 8;
    localparam int STEP_W              = 5;
    localparam int PHASE_W             = 2;
    localparam int PITCH_W             = 4;
    localparam int LIMIT_W             = 4;
    localparam int PERIOD_W            = LIMIT_W + 1;
    localparam int STEP_TICK_BITS      = 7;

    localparam int OCTAVE_BIT          = 4;
    localparam int LONG_STEP_BIT       = 5;

    localparam logic [PITCH_W-1:0] PITCH_END   = 4'd1;
    localparam logic [PITCH_W-1:0] PITCH_LO    = 4'd2;
    localparam logic [PITCH_W-1:0] PITCH_HI    = 4'd13;

    localparam logic [STEP_W-1:0]  STEP_MASK_SHORT = 5'h0f;
    localparam logic [STEP_W-1:0]  STEP_MASK_LONG  = 5'h1f;

    typedef enum logic
    {
        CMD_TICK = 1'b0,
        CMD_LOAD = 1'b1
    } cmd_t;

    typedef struct packed
    {
        cmd_t                cmd;
        logic                melody_enable;
        logic [ADDR_W-1:0]   load_address;
        logic [NOTE_W-1:0]   load_data;
    } item_t;

    typedef struct packed
    {
        logic tone_out;
        logic melody_done;
        logic one_second;
    } result_t;

    // Phase length per duty phase (upper two index bits) and pitch (lower four).
    localparam logic [LIMIT_W-1:0] TONE_TABLE [64] = '{
        4'd0, 4'd0, 4'd7, 4'd8, 4'd8, 4'd9, 4'd9, 4'd10,
        4'd11, 4'd11, 4'd12, 4'd13, 4'd14, 4'd14, 4'd0, 4'd0,
        4'd0, 4'd0, 4'd8, 4'd8, 4'd9, 4'd9, 4'd10, 4'd11,
        4'd11, 4'd12, 4'd13, 4'd13, 4'd14, 4'd15, 4'd0, 4'd0,
        4'd0, 4'd0, 4'd8, 4'd8, 4'd9, 4'd9, 4'd10, 4'd10,
        4'd11, 4'd12, 4'd12, 4'd13, 4'd14, 4'd15, 4'd0, 4'd0,
        4'd0, 4'd0, 4'd8, 4'd9, 4'd9, 4'd10, 4'd10, 4'd11,
        4'd11, 4'd12, 4'd13, 4'd14, 4'd14, 4'd15, 4'd0, 4'd0
    };

endpackage

// File: hw/rtl/rmtg_store.sv
// Melody store: one write port, one registered read port with write-through on an address match.
// Depends on rmtg_pkg for the note width.
`timescale 1ns / 1ps

module rmtg_store #(
    parameter int DEPTH = rmtg_pkg::STORE_DEPTH_DEFAULT,
    parameter int AW    = 8
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [AW-1:0]                 wr_addr,
    input  logic [rmtg_pkg::NOTE_W-1:0]   wr_data,
    input  logic [AW-1:0]                 rd_addr,
    output logic [rmtg_pkg::NOTE_W-1:0]   rd_data
);

    logic [rmtg_pkg::NOTE_W-1:0] mem [DEPTH];
    logic [rmtg_pkg::NOTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // pass fresh write data through when it lands on the entry being read
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/rom_melody_tone_generator.sv
// Top level of the melody tone generator: input register, note/tone logic, result register.
// Depends on rmtg_pkg and rmtg_store.
`timescale 1ns / 1ps

// Usage
//   item channel: item_valid / item_stall / item (rmtg_pkg::item_t). A beat with
//     cmd = CMD_LOAD writes load_data into the melody store at load_address;
//     a beat with cmd = CMD_TICK is one divider tick that plays the current note.
//   result channel: result_valid / result_stall / result (rmtg_pkg::result_t).
//     Every item beat yields exactly one result beat, in order.
// Pipeline and throughput
//   One item per cycle sustained while result_stall stays low. A result beat is
//   offered once its item beat has passed through the input register and then
//   the result register. The rate is set by the melody store read port, which
//   is re-addressed every cycle with the note address that the previous tick leaves behind.
// Reset
//   rst_n clears the divider, duty state, step counter, note address, the done
//   flag and both valid bits. Store contents stay undefined until loaded.
// Backpressure
//   While result_stall holds, the result register holds its beat; the input
//   register then fills, and item_stall rises until the result is taken.

module rom_melody_tone_generator #(
    parameter int STORE_DEPTH = rmtg_pkg::STORE_DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  rmtg_pkg::item_t    item,
    output logic               result_valid,
    input  logic               result_stall,
    output rmtg_pkg::result_t  result
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int ADDR_SPAN = 1 << rmtg_pkg::ADDR_W;

    // input stage
    logic                              s0_valid_reg;
    rmtg_pkg::item_t                   s0_item_reg;
    logic                              s0_advance;
    logic                              item_accept;

    // result stage
    logic                              result_valid_reg;
    rmtg_pkg::result_t                 result_reg;
    rmtg_pkg::result_t                 result_next;

    // tone state
    logic [rmtg_pkg::DIV_W-1:0]        divider_reg;
    logic [rmtg_pkg::DIV_W-1:0]        divider_next;
    logic [rmtg_pkg::DUTY_W-1:0]       duty_counter_reg;
    logic [rmtg_pkg::DUTY_W-1:0]       duty_counter_next;
    logic [rmtg_pkg::PHASE_W-1:0]      duty_phase_reg;
    logic [rmtg_pkg::PHASE_W-1:0]      duty_phase_next;
    logic [rmtg_pkg::STEP_W-1:0]       step_counter_reg;
    logic [rmtg_pkg::STEP_W-1:0]       step_counter_next;
    logic [rmtg_pkg::ADDR_W-1:0]       note_address_reg;
    logic [rmtg_pkg::ADDR_W-1:0]       note_address_next;
    logic                              done_flag_reg;
    logic                              done_flag_next;

    // note decode
    logic [rmtg_pkg::NOTE_W-1:0]       note;
    logic [rmtg_pkg::PITCH_W-1:0]      pitch;
    logic [rmtg_pkg::LIMIT_W-1:0]      limit;
    logic [rmtg_pkg::PERIOD_W-1:0]     period;
    logic [rmtg_pkg::DUTY_W-1:0]       duty_inc;
    logic [rmtg_pkg::STEP_W-1:0]       step_mask;
    logic [rmtg_pkg::STEP_W-1:0]       step_inc;

    // store access
    logic                              wr_en;
    logic [AW-1:0]                     wr_index;
    logic [AW-1:0]                     rd_index;
    logic [AW-1:0]                     mod_lut [ADDR_SPAN];

    // ------------------------------------------------------------------
    // Handshake: the input register advances whenever the result register
    // is empty or being drained.
    // ------------------------------------------------------------------
    assign s0_advance  = s0_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall  = s0_valid_reg && !s0_advance;
    assign item_accept = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (item_accept)
        begin
            s0_valid_reg <= 1'b1;
        end
        else if (s0_advance)
        begin
            s0_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            s0_item_reg <= item;
        end
    end

    // ------------------------------------------------------------------
    // Store addressing: byte address modulo the store depth, from a table
    // fixed at elaboration.
    // ------------------------------------------------------------------
    for (genvar g = 0; g < ADDR_SPAN; g++)
    begin : g_mod_lut
        assign mod_lut[g] = AW'(g % STORE_DEPTH);
    end

    assign wr_index = mod_lut[s0_item_reg.load_address];
    // read the entry the next tick will play
    assign rd_index = mod_lut[note_address_next];

    rmtg_store #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_index),
        .wr_data (s0_item_reg.load_data),
        .rd_addr (rd_index),
        .rd_data (note)
    );

    // ------------------------------------------------------------------
    // Note and tone logic for the beat in the input register.
    // ------------------------------------------------------------------
    assign pitch    = note[rmtg_pkg::PITCH_W-1:0];
    assign limit    = rmtg_pkg::TONE_TABLE[{duty_phase_reg, pitch}];
    // low octave doubles the phase length
    assign period   = note[rmtg_pkg::OCTAVE_BIT] ? {1'b0, limit} : {limit, 1'b0};
    assign duty_inc = duty_counter_reg + 8'd1;
    assign step_mask = note[rmtg_pkg::LONG_STEP_BIT] ? rmtg_pkg::STEP_MASK_LONG
                                                     : rmtg_pkg::STEP_MASK_SHORT;
    assign step_inc = (step_counter_reg + 5'd1) & step_mask;

    always_comb
    begin
        divider_next      = divider_reg;
        duty_counter_next = duty_counter_reg;
        duty_phase_next   = duty_phase_reg;
        step_counter_next = step_counter_reg;
        note_address_next = note_address_reg;
        done_flag_next    = done_flag_reg;
        wr_en             = 1'b0;
        result_next.tone_out   = 1'b0;
        result_next.one_second = 1'b0;

        if (s0_advance)
        begin
            case (s0_item_reg.cmd)
                rmtg_pkg::CMD_LOAD:
                begin
                    wr_en = 1'b1;
                end
                rmtg_pkg::CMD_TICK:
                begin
                    divider_next = divider_reg + 15'd1;
                    result_next.one_second = (divider_next == '0);

                    if (pitch inside {[rmtg_pkg::PITCH_LO:rmtg_pkg::PITCH_HI]})
                    begin
                        result_next.tone_out = duty_phase_reg[0] & s0_item_reg.melody_enable;
                        duty_counter_next = duty_inc;
                        if (duty_inc >= {3'b000, period})
                        begin
                            duty_counter_next = '0;
                            duty_phase_next   = duty_phase_reg + 2'd1;
                        end
                    end
                    else if (pitch == rmtg_pkg::PITCH_END)
                    begin
                        done_flag_next = 1'b1;
                    end

                    // step once every 128 ticks; move to the next note on wrap
                    if (divider_next[rmtg_pkg::STEP_TICK_BITS-1:0] == '0)
                    begin
                        step_counter_next = step_inc;
                        if (step_inc == '0)
                        begin
                            note_address_next = note_address_reg + 8'd1;
                        end
                    end
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end

        result_next.melody_done = done_flag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divider_reg      <= '0;
            duty_counter_reg <= '0;
            duty_phase_reg   <= '0;
            step_counter_reg <= '0;
            note_address_reg <= '0;
            done_flag_reg    <= 1'b0;
        end
        else
        begin
            divider_reg      <= divider_next;
            duty_counter_reg <= duty_counter_next;
            duty_phase_reg   <= duty_phase_next;
            step_counter_reg <= step_counter_next;
            note_address_reg <= note_address_next;
            done_flag_reg    <= done_flag_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register: load on advance, drop the beat once taken.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (s0_advance)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef NO_ASSERTIONS
    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (s0_valid_reg && result_valid_reg))
        else $error("input stalled without a held result");

    a_load_is_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (s0_advance && (s0_item_reg.cmd == rmtg_pkg::CMD_LOAD))
        |=> (!result_reg.tone_out && !result_reg.one_second))
        else $error("load beat produced tone or one-second pulse");

    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        done_flag_reg |=> done_flag_reg)
        else $error("done flag cleared");

    a_phase_restarts_count: assert property (@(posedge clk) disable iff (!rst_n)
        (duty_phase_reg != duty_phase_next) |=> (duty_counter_reg == '0))
        else $error("duty phase moved without restarting its count");

    a_note_moves_on_step: assert property (@(posedge clk) disable iff (!rst_n)
        (note_address_reg != note_address_next)
        |-> (divider_next[rmtg_pkg::STEP_TICK_BITS-1:0] == '0 && step_counter_next == '0))
        else $error("note address moved off a step boundary");
`endif

endmodule
